### rtl/subsequence_string_kernel_macros.svh
// ----------------------------------------------------------------------------
// Subsequence string kernel assertion macros
// Shared concurrent assertion forms for the kernel RTL.
// ----------------------------------------------------------------------------
`ifndef SUBSEQUENCE_STRING_KERNEL_MACROS_SVH
`define SUBSEQUENCE_STRING_KERNEL_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define SSK_ASSERT_NOW(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset.
`define SSK_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/ssk_pkg.sv
// ----------------------------------------------------------------------------
// ssk_pkg
// Types and constants shared by the subsequence string kernel modules.
// ----------------------------------------------------------------------------
`default_nettype none

package ssk_pkg;

    // Default sizes.
    localparam int DEF_MAX_STR_LEN = 64;
    localparam int DEF_MAX_SUBSEQ  = 16;
    localparam int DEF_FRAC_BITS   = 16;
    localparam int DEF_VALUE_WIDTH = 48;

    // Fixed field widths.
    localparam int REQ_W    = 2;
    localparam int CHAR_W   = 8;
    localparam int SUBSEQ_W = 5;
    localparam int LAM_W    = 17;
    localparam int CHUNK_W  = 16;

    // Register reset values.
    localparam logic [SUBSEQ_W-1:0] RST_SUBSEQ_LEN = 5'd2;
    localparam logic [LAM_W-1:0]    RST_DECAY      = 17'd32768;

    // Request codes.
    localparam logic [REQ_W-1:0] REQ_FIRST   = 2'd0;
    localparam logic [REQ_W-1:0] REQ_SECOND  = 2'd1;
    localparam logic [REQ_W-1:0] REQ_COMPUTE = 2'd2;

    // Register indexes.
    localparam logic REG_SUBSEQ_LEN = 1'b0;
    localparam logic REG_DECAY      = 1'b1;

    // Sequencer states.
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_LAM2,
        ST_C_RD,
        ST_C_CAP,
        ST_C_MUL,
        ST_U_RD1,
        ST_U_RD2,
        ST_U_CAP,
        ST_U_MT,
        ST_U_MR,
        ST_U_MB,
        ST_DONE
    } state_t;

    // Status from the multiplier unit.
    typedef struct packed {
        logic done;
        logic sat;
    } mul_stat_t;

endpackage

`default_nettype wire

### rtl/ssk_ram.sv
// ----------------------------------------------------------------------------
// ssk_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module ssk_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write and registered read.
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

### rtl/ssk_mul.sv
// ----------------------------------------------------------------------------
// ssk_mul
// Iterative fixed point multiplier: one 16-bit slice of the wide operand per
// cycle, most significant slice first, then scaling and saturation.
// ----------------------------------------------------------------------------
`default_nettype none

module ssk_mul
    import ssk_pkg::*;
#(
    parameter int VALUE_WIDTH = DEF_VALUE_WIDTH,
    parameter int FRAC_BITS   = DEF_FRAC_BITS,
    parameter int A_W         = LAM_W
) (
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire logic                   start,
    input  wire logic [A_W-1:0]         a,
    input  wire logic [VALUE_WIDTH-1:0] b,
    output logic      [VALUE_WIDTH-1:0] result,
    output mul_stat_t                   stat
);

    localparam int NCH   = (VALUE_WIDTH + CHUNK_W - 1) / CHUNK_W;
    localparam int BW    = NCH * CHUNK_W;
    localparam int PW    = A_W + BW;
    localparam int SW    = FRAC_BITS + VALUE_WIDTH + 1;
    localparam int ACC_W = (PW > SW) ? PW : SW;
    localparam int CW    = $clog2(NCH + 1);

    logic [A_W-1:0]         a_reg;
    logic [BW-1:0]          b_sh_reg, b_sh_next;
    logic [ACC_W-1:0]       acc_reg, acc_next;
    logic [CW-1:0]          cnt_reg, cnt_next;
    logic                   done_reg, done_next;
    logic [A_W+CHUNK_W-1:0] prod;

    assign prod = a_reg * b_sh_reg[BW-1 -: CHUNK_W];

    // Shift-accumulate step.
    always_comb begin
        b_sh_next = b_sh_reg;
        acc_next  = acc_reg;
        cnt_next  = cnt_reg;
        done_next = 1'b0;
        if (start) begin
            b_sh_next = BW'(b);
            acc_next  = '0;
            cnt_next  = CW'(NCH);
        end else if (cnt_reg != '0) begin
            b_sh_next = b_sh_reg << CHUNK_W;
            acc_next  = (acc_reg << CHUNK_W) + ACC_W'(prod);
            cnt_next  = cnt_reg - 1'b1;
            done_next = (cnt_reg == CW'(1));
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end else begin
            cnt_reg  <= cnt_next;
            done_reg <= done_next;
        end
        if (start) begin
            a_reg <= a;
        end
        b_sh_reg <= b_sh_next;
        acc_reg  <= acc_next;
    end

    // Scale down and saturate.
    always_comb begin
        stat.done = done_reg;
        stat.sat  = |acc_reg[ACC_W-1:FRAC_BITS+VALUE_WIDTH];
        result    = stat.sat ? {VALUE_WIDTH{1'b1}} : acc_reg[FRAC_BITS +: VALUE_WIDTH];
    end

endmodule

`default_nettype wire

### rtl/subsequence_string_kernel.sv
// ----------------------------------------------------------------------------
// subsequence_string_kernel
// Gap-weighted subsequence string kernel over two loaded byte strings, with
// the prefix table held in a synchronous RAM and a shared iterative multiplier.
// ----------------------------------------------------------------------------
//  Channel  Ports                                  Direction  Use
//  s_       s_valid s_ready s_req_type s_char_code in         load / compute
//  m_       m_valid m_ready m_kernel_value ...     out        one word per compute
//  apb      psel penable pwrite paddr pwdata ...   in         subseq_len, decay
//
// Character loads are accepted back to back in idle.
// A compute runs, per layer, la*lb compare cells and (la-1)*(lb-1) update cells.
// NCH = ceil(VALUE_WIDTH/16) is the multiplier's slice count.
// No clearing pass: reset makes the block ready on the next cycle.
// A compute is held off while the previous result word waits in m_.
// ----------------------------------------------------------------------------
`default_nettype none

module subsequence_string_kernel
    import ssk_pkg::*;
#(
    parameter int MAX_STR_LEN = DEF_MAX_STR_LEN,
    parameter int MAX_SUBSEQ  = DEF_MAX_SUBSEQ,
    parameter int FRAC_BITS   = DEF_FRAC_BITS,
    parameter int VALUE_WIDTH = DEF_VALUE_WIDTH
) (
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire logic                   s_valid,
    output logic                        s_ready,
    input  wire logic [REQ_W-1:0]       s_req_type,
    input  wire logic [CHAR_W-1:0]      s_char_code,
    output logic                        m_valid,
    input  wire logic                   m_ready,
    output logic [VALUE_WIDTH-1:0]      m_kernel_value,
    output logic                        m_saturated,
    output logic                        m_too_long,
    input  wire logic                   psel,
    input  wire logic                   penable,
    input  wire logic                   pwrite,
    input  wire logic [2:0]             paddr,
    input  wire logic [31:0]            pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready
);

    `include "subsequence_string_kernel_macros.svh"

    localparam int VW    = VALUE_WIDTH;
    localparam int IW    = (MAX_STR_LEN > 1) ? $clog2(MAX_STR_LEN) : 1;
    localparam int LENW  = $clog2(MAX_STR_LEN + 1);
    localparam int LW    = $clog2(MAX_SUBSEQ + 1);
    localparam int TAW   = 1 + 2 * IW;
    localparam int L2W   = 2 * LAM_W + 1 - FRAC_BITS;
    localparam int A_MIN = (VW < L2W) ? VW : L2W;
    localparam int A_W   = (A_MIN > LAM_W) ? A_MIN : LAM_W;
    localparam bit ONE_SAT = (FRAC_BITS >= VW);
    localparam logic [VW-1:0] VMAX    = {VW{1'b1}};
    localparam logic [VW-1:0] ONE_VAL = ONE_SAT ? VMAX : (VW'(1) << FRAC_BITS);

    // Control and datapath registers.
    state_t               state_reg, state_next;
    logic [SUBSEQ_W-1:0]  subseq_reg;
    logic [LAM_W-1:0]     decay_reg;
    logic [LENW-1:0]      la_reg, la_next, lb_reg, lb_next;
    logic                 drop_reg, drop_next, ovf_reg, ovf_next;
    logic [LW-1:0]        len_reg, len_next, i_reg, i_next;
    logic [IW-1:0]        j_reg, j_next, k_reg, k_next;
    logic [VW-1:0]        sum_reg, sum_next, rp_reg, rp_next;
    logic [VW-1:0]        a_val_reg, a_val_next, b_val_reg, b_val_next;
    logic                 match_reg, match_next;
    logic [A_W-1:0]       lam2_reg, lam2_next;
    logic                 m_valid_reg, m_valid_next;
    logic [VW-1:0]        m_kv_reg;
    logic                 m_sat_reg, m_tl_reg;

    // Memory and arithmetic hookups.
    logic                 sa_we, sb_we;
    logic [CHAR_W-1:0]    sa_rdata, sb_rdata;
    logic                 tbl_we;
    logic [TAW-1:0]       tbl_waddr, tbl_raddr;
    logic [VW-1:0]        tbl_wdata, tbl_rdata;
    logic                 mul_start;
    logic [A_W-1:0]       mul_a;
    logic [VW-1:0]        mul_b, mul_res;
    mul_stat_t            mul_stat;
    logic [VW-1:0]        add_a, add_b, add_res;
    logic [VW:0]          add_s;
    logic                 add_sat;

    // Loop bounds.
    logic [LENW:0]        jp1, jp2, kp1, kp2;
    logic [LW:0]          ip1;
    logic [LW-1:0]        len_eff;
    logic                 s_acc, is_load_a, is_load_b, is_comp;
    logic                 str_match, a_zero;
    logic [IW-1:0]        kn;

    assign jp1 = (LENW + 1)'(j_reg) + 1'b1;
    assign jp2 = jp1 + 1'b1;
    assign kp1 = (LENW + 1)'(k_reg) + 1'b1;
    assign kp2 = kp1 + 1'b1;
    assign ip1 = (LW + 1)'(i_reg) + 1'b1;
    assign kn  = IW'(kp1);
    assign len_eff = ((32'(subseq_reg)) > MAX_SUBSEQ) ? LW'(MAX_SUBSEQ) : LW'(subseq_reg);

    assign s_ready   = (state_reg == ST_IDLE) && (!m_valid_reg || s_req_type != REQ_COMPUTE);
    assign s_acc     = s_valid && s_ready;
    assign is_load_a = s_acc && (s_req_type == REQ_FIRST);
    assign is_load_b = s_acc && (s_req_type == REQ_SECOND);
    assign is_comp   = s_acc && (s_req_type == REQ_COMPUTE);
    assign str_match = (sa_rdata == sb_rdata);
    assign a_zero    = (j_reg == '0) || (k_reg == '0);

    assign m_valid        = m_valid_reg;
    assign m_kernel_value = m_kv_reg;
    assign m_saturated    = m_sat_reg;
    assign m_too_long     = m_tl_reg;

    // Configuration port.
    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_DECAY) ? 32'(decay_reg) : 32'(subseq_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            subseq_reg <= RST_SUBSEQ_LEN;
            decay_reg  <= RST_DECAY;
        end else if (psel && penable && pwrite && pready) begin
            if (paddr[2] == REG_DECAY) begin
                decay_reg <= pwdata[LAM_W-1:0];
            end else begin
                subseq_reg <= pwdata[SUBSEQ_W-1:0];
            end
        end
    end

    // Saturating adder shared by all sums.
    always_comb begin
        add_a = sum_reg;
        add_b = mul_res;
        case (state_reg)
            ST_U_MT: begin
                add_a = rp_reg;
                add_b = mul_res;
            end
            ST_U_MB: begin
                add_a = mul_res;
                add_b = rp_reg;
            end
            default: begin
                add_a = sum_reg;
                add_b = mul_res;
            end
        endcase
        add_s   = {1'b0, add_a} + {1'b0, add_b};
        add_sat = add_s[VW];
        add_res = add_sat ? VMAX : add_s[VW-1:0];
    end

    // Next state.
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (is_comp) begin
                    state_next = ST_LAM2;
                end
            end
            ST_LAM2: begin
                if (mul_stat.done) begin
                    if (len_eff == '0 || la_reg == '0 || lb_reg == '0) begin
                        state_next = ST_DONE;
                    end else begin
                        state_next = ST_C_RD;
                    end
                end
            end
            ST_C_RD: state_next = ST_C_CAP;
            ST_C_CAP, ST_C_MUL: begin
                if (state_reg == ST_C_CAP && str_match) begin
                    state_next = ST_C_MUL;
                end else if (state_reg == ST_C_CAP || mul_stat.done) begin
                    if (kp1 < (LENW + 1)'(lb_reg) || jp1 < (LENW + 1)'(la_reg)) begin
                        state_next = ST_C_RD;
                    end else if (ip1 >= (LW + 1)'(len_reg)) begin
                        state_next = ST_DONE;
                    end else if (la_reg < LENW'(2) || lb_reg < LENW'(2)) begin
                        state_next = ST_C_RD;
                    end else begin
                        state_next = ST_U_RD1;
                    end
                end
            end
            ST_U_RD1: state_next = ST_U_RD2;
            ST_U_RD2: state_next = ST_U_CAP;
            ST_U_CAP: state_next = match_reg ? ST_U_MT : ST_U_MR;
            ST_U_MT: begin
                if (mul_stat.done) begin
                    state_next = ST_U_MR;
                end
            end
            ST_U_MR: begin
                if (mul_stat.done) begin
                    state_next = ST_U_MB;
                end
            end
            ST_U_MB: begin
                if (mul_stat.done) begin
                    if (kp2 < (LENW + 1)'(lb_reg) || jp2 < (LENW + 1)'(la_reg)) begin
                        state_next = ST_U_RD1;
                    end else begin
                        state_next = ST_C_RD;
                    end
                end
            end
            ST_DONE: state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    // Datapath and memory controls.
    always_comb begin
        la_next      = la_reg;
        lb_next      = lb_reg;
        drop_next    = drop_reg;
        ovf_next     = ovf_reg;
        len_next     = len_reg;
        i_next       = i_reg;
        j_next       = j_reg;
        k_next       = k_reg;
        sum_next     = sum_reg;
        rp_next      = rp_reg;
        a_val_next   = a_val_reg;
        b_val_next   = b_val_reg;
        match_next   = match_reg;
        lam2_next    = lam2_reg;
        m_valid_next = m_valid_reg && !m_ready;
        sa_we        = 1'b0;
        sb_we        = 1'b0;
        tbl_we       = 1'b0;
        tbl_waddr    = {~i_reg[0], IW'(jp1), kn};
        tbl_wdata    = add_res;
        tbl_raddr    = {i_reg[0], j_reg, k_reg};
        mul_start    = 1'b0;
        mul_a        = A_W'(decay_reg);
        mul_b        = a_val_reg;
        case (state_reg)
            ST_IDLE: begin
                if (is_load_a) begin
                    if (la_reg < LENW'(MAX_STR_LEN)) begin
                        sa_we   = 1'b1;
                        la_next = la_reg + 1'b1;
                    end else begin
                        drop_next = 1'b1;
                    end
                end
                if (is_load_b) begin
                    if (lb_reg < LENW'(MAX_STR_LEN)) begin
                        sb_we   = 1'b1;
                        lb_next = lb_reg + 1'b1;
                    end else begin
                        drop_next = 1'b1;
                    end
                end
                if (is_comp) begin
                    mul_start = 1'b1;
                    mul_b     = VW'(decay_reg);
                    ovf_next  = ONE_SAT;
                    sum_next  = '0;
                    rp_next   = '0;
                    len_next  = len_eff;
                    i_next    = '0;
                    j_next    = '0;
                    k_next    = '0;
                end
            end
            ST_LAM2: begin
                if (mul_stat.done) begin
                    lam2_next = A_W'(mul_res);
                    ovf_next  = ovf_reg | mul_stat.sat;
                end
            end
            ST_C_CAP, ST_C_MUL: begin
                if (state_reg == ST_C_CAP) begin
                    a_val_next = (i_reg == '0) ? ONE_VAL : (a_zero ? '0 : tbl_rdata);
                    mul_a      = lam2_reg;
                    mul_b      = (i_reg == '0) ? ONE_VAL : (a_zero ? '0 : tbl_rdata);
                    mul_start  = str_match;
                end else if (mul_stat.done) begin
                    sum_next = add_res;
                    ovf_next = ovf_reg | mul_stat.sat | add_sat;
                end
                if ((state_reg == ST_C_CAP && !str_match) || mul_stat.done) begin
                    if (kp1 < (LENW + 1)'(lb_reg)) begin
                        k_next = kn;
                    end else if (jp1 < (LENW + 1)'(la_reg)) begin
                        j_next = IW'(jp1);
                        k_next = '0;
                    end else begin
                        j_next  = '0;
                        k_next  = '0;
                        rp_next = '0;
                        if (!(la_reg < LENW'(2) || lb_reg < LENW'(2))) begin
                            i_next = i_reg;
                        end else begin
                            i_next = LW'(ip1);
                        end
                    end
                end
            end
            ST_U_RD2: begin
                a_val_next = (i_reg == '0) ? ONE_VAL : (a_zero ? '0 : tbl_rdata);
                match_next = str_match;
                tbl_raddr  = {~i_reg[0], j_reg, kn};
            end
            ST_U_CAP: begin
                b_val_next = (j_reg == '0) ? '0 : tbl_rdata;
                mul_start  = 1'b1;
                mul_b      = match_reg ? a_val_reg : rp_reg;
            end
            ST_U_MT: begin
                if (mul_stat.done) begin
                    ovf_next  = ovf_reg | mul_stat.sat | add_sat;
                    mul_start = 1'b1;
                    mul_b     = add_res;
                end
            end
            ST_U_MR: begin
                if (mul_stat.done) begin
                    rp_next   = mul_res;
                    ovf_next  = ovf_reg | mul_stat.sat;
                    mul_start = 1'b1;
                    mul_b     = b_val_reg;
                end
            end
            ST_U_MB: begin
                if (mul_stat.done) begin
                    tbl_we   = 1'b1;
                    ovf_next = ovf_reg | mul_stat.sat | add_sat;
                    if (kp2 < (LENW + 1)'(lb_reg)) begin
                        k_next = kn;
                    end else if (jp2 < (LENW + 1)'(la_reg)) begin
                        j_next  = IW'(jp1);
                        k_next  = '0;
                        rp_next = '0;
                    end else begin
                        j_next = '0;
                        k_next = '0;
                        i_next = LW'(ip1);
                    end
                end
            end
            ST_DONE: begin
                m_valid_next = 1'b1;
                la_next      = '0;
                lb_next      = '0;
                drop_next    = 1'b0;
                ovf_next     = 1'b0;
            end
            default: begin
                m_valid_next = m_valid_reg && !m_ready;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            la_reg      <= '0;
            lb_reg      <= '0;
            drop_reg    <= 1'b0;
            ovf_reg     <= 1'b0;
            m_valid_reg <= 1'b0;
            len_reg     <= '0;
            i_reg       <= '0;
            j_reg       <= '0;
            k_reg       <= '0;
            sum_reg     <= '0;
            rp_reg      <= '0;
        end else begin
            state_reg   <= state_next;
            la_reg      <= la_next;
            lb_reg      <= lb_next;
            drop_reg    <= drop_next;
            ovf_reg     <= ovf_next;
            m_valid_reg <= m_valid_next;
            len_reg     <= len_next;
            i_reg       <= i_next;
            j_reg       <= j_next;
            k_reg       <= k_next;
            sum_reg     <= sum_next;
            rp_reg      <= rp_next;
        end
        a_val_reg <= a_val_next;
        b_val_reg <= b_val_next;
        match_reg <= match_next;
        lam2_reg  <= lam2_next;
        // Result word, loaded as the compute finishes.
        if (state_reg == ST_DONE) begin
            m_kv_reg  <= sum_reg;
            m_sat_reg <= ovf_reg;
            m_tl_reg  <= drop_reg;
        end
    end

    // String stores and prefix table.
    ssk_ram #(.WIDTH(CHAR_W), .DEPTH(2 ** IW)) u_str_a (
        .aclk  (aclk),
        .we    (sa_we),
        .waddr (la_reg[IW-1:0]),
        .wdata (s_char_code),
        .raddr (j_reg),
        .rdata (sa_rdata)
    );

    ssk_ram #(.WIDTH(CHAR_W), .DEPTH(2 ** IW)) u_str_b (
        .aclk  (aclk),
        .we    (sb_we),
        .waddr (lb_reg[IW-1:0]),
        .wdata (s_char_code),
        .raddr (k_reg),
        .rdata (sb_rdata)
    );

    ssk_ram #(.WIDTH(VW), .DEPTH(2 ** TAW)) u_table (
        .aclk  (aclk),
        .we    (tbl_we),
        .waddr (tbl_waddr),
        .wdata (tbl_wdata),
        .raddr (tbl_raddr),
        .rdata (tbl_rdata)
    );

    ssk_mul #(.VALUE_WIDTH(VW), .FRAC_BITS(FRAC_BITS), .A_W(A_W)) u_mul (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (mul_start),
        .a       (mul_a),
        .b       (mul_b),
        .result  (mul_res),
        .stat    (mul_stat)
    );

    // Checks on sequencing.
    `SSK_ASSERT_NEXT(a_done_word, aclk, aresetn, state_reg == ST_DONE, m_valid_reg, "no result word after compute")
    `SSK_ASSERT_NOW(a_mul_wait, aclk, aresetn, mul_stat.done, state_reg == ST_LAM2 || state_reg == ST_C_MUL || state_reg == ST_U_MT || state_reg == ST_U_MR || state_reg == ST_U_MB, "multiplier result with nobody waiting")
    `SSK_ASSERT_NOW(a_len_cap, aclk, aresetn, 1'b1, la_reg <= LENW'(MAX_STR_LEN) && lb_reg <= LENW'(MAX_STR_LEN), "string length over capacity")

endmodule

`default_nettype wire
